// ===== src/brtxt_pkg.sv =====
`default_nettype none

package brtxt_pkg;

	// default line store depth, pixels per row
	localparam int unsigned BRT_MAX_WIDTH = 1024;

	// register field and reset
	localparam int unsigned IMG_WIDTH_W = 11;
	localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RST = 11'd128;

	// luma weights, 0.21 / 0.72 / 0.07 in 256ths, plus rounding
	localparam logic [7:0] LUMA_R = 8'd54;
	localparam logic [7:0] LUMA_G = 8'd184;
	localparam logic [7:0] LUMA_B = 8'd18;
	localparam logic [15:0] LUMA_RND = 16'd128;

	// utf-8 bytes of a braille character and the line break
	localparam logic [7:0] UTF8_LEAD = 8'hE2;
	localparam logic [7:0] UTF8_MID = 8'hA0;
	localparam logic [7:0] UTF8_TAIL = 8'h80;
	localparam logic [7:0] NEWLINE = 8'h0A;

	// last row of a band, the one that completes cells
	localparam logic [1:0] BAND_LAST_ROW = 2'd3;

	// cell queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		POS_LEAD,
		POS_MID,
		POS_TAIL,
		POS_NEWLINE
	} byte_pos_t;

	// one finished cell: braille dot bits and the end-of-row flag
	typedef struct packed {
		logic [7:0] bits;
		logic newline;
	} cell_req_t;

	typedef struct packed {
		logic valid;
		cell_req_t req;
	} cell_push_t;

	typedef struct packed {
		logic valid;
		cell_req_t req;
	} cell_head_t;

endpackage

`default_nettype wire

// ===== src/brtxt_front.sv =====
`default_nettype none

module brtxt_front #(
	parameter int unsigned MAX_WIDTH = brtxt_pkg::BRT_MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [brtxt_pkg::IMG_WIDTH_W-1:0] image_width,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [7:0] noise,
	input wire logic frame_start,
	output brtxt_pkg::cell_push_t push,
	input wire logic queue_full
);
	import brtxt_pkg::*;

	localparam int unsigned AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned MW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WW = (MW > IMG_WIDTH_W) ? MW : IMG_WIDTH_W;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
	localparam logic [WW-1:0] MIN_W = WW'(2);

	logic [2:0] line_mem [MAX_WIDTH];

	logic [AW-1:0] col_q;
	logic [1:0] band_q;
	logic [3:0] left_q;

	logic s1_valid_q;
	logic [7:0] red_s1, green_s1, blue_s1, noise_s1;
	logic start_s1;
	logic [1:0] band_s1;
	logic odd_s1;
	logic wrap_s1;
	logic [AW-1:0] idx_s1;
	logic [2:0] stored_s1;

	logic [WW-1:0] width_ext, eff_w;
	logic [AW-1:0] col_cur;
	logic [1:0] band_cur;
	logic wrap;
	logic accept;
	logic [15:0] luma_sum;
	logic dot;
	logic is_cell;
	logic leave;
	logic [2:0] wr_data;

	// effective width: clamp to [2, MAX_WIDTH], force even
	always_comb begin
		width_ext = WW'(image_width);
		if (width_ext < MIN_W) begin
			eff_w = MIN_W;
		end else if (width_ext > MAX_W) begin
			eff_w = MAX_W;
		end else begin
			eff_w = width_ext;
		end
		eff_w[0] = 1'b0;
	end

	assign col_cur = frame_start ? '0 : col_q;
	assign band_cur = frame_start ? 2'd0 : band_q;
	assign wrap = (WW'(col_cur) + WW'(1)) >= eff_w;
	assign accept = in_valid && in_ready;

	// stage 1 work: luma, dot, cell assembly
	assign luma_sum = 16'(LUMA_R) * 16'(red_s1) + 16'(LUMA_G) * 16'(green_s1)
		+ 16'(LUMA_B) * 16'(blue_s1) + LUMA_RND;
	assign dot = noise_s1 < luma_sum[15:8];
	assign is_cell = (band_s1 == BAND_LAST_ROW) && odd_s1;
	assign leave = s1_valid_q && (!is_cell || !queue_full);
	assign in_ready = !s1_valid_q || leave;

	assign push.valid = s1_valid_q && is_cell;
	assign push.req.bits = {dot, left_q[3], stored_s1, left_q[2:0]};
	assign push.req.newline = wrap_s1;

	always_comb begin
		wr_data = stored_s1;
		case (band_s1)
			2'd0: wr_data = {2'b00, dot};
			2'd1: wr_data[1] = dot;
			2'd2: wr_data[2] = dot;
			default: wr_data = stored_s1;
		endcase
	end

	// raster position, advanced as each pixel is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			band_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (wrap) begin
					col_q <= '0;
					band_q <= band_cur + 2'd1;
				end else begin
					col_q <= col_cur + AW'(1);
					band_q <= band_cur;
				end
				s1_valid_q <= 1'b1;
			end else if (leave) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// left half of the cell in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (leave) begin
			if (start_s1) begin
				left_q <= '0;
			end else if ((band_s1 == BAND_LAST_ROW) && !odd_s1) begin
				left_q <= {dot, stored_s1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1 <= red;
			green_s1 <= green;
			blue_s1 <= blue;
			noise_s1 <= noise;
			start_s1 <= frame_start;
			band_s1 <= band_cur;
			odd_s1 <= col_cur[0];
			wrap_s1 <= wrap;
			idx_s1 <= col_cur;
		end
	end

	// line store: read as the pixel is taken, written as a row 0..2 pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			stored_s1 <= line_mem[col_cur];
		end
		if (leave && (band_s1 != BAND_LAST_ROW)) begin
			line_mem[idx_s1] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/brtxt_queue.sv =====
`default_nettype none

module brtxt_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire brtxt_pkg::cell_push_t push,
	output logic full,
	output brtxt_pkg::cell_head_t head,
	input wire logic pop
);
	import brtxt_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	cell_req_t slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == CW'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.req = slots_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.req;
		end
	end

endmodule

`default_nettype wire

// ===== src/brtxt_back.sv =====
`default_nettype none

module brtxt_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire brtxt_pkg::cell_head_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic out_last
);
	import brtxt_pkg::*;

	logic active_q;
	cell_req_t cur_q;
	byte_pos_t pos_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic load;
	logic [7:0] next_byte;
	logic next_last;

	always_comb begin
		next_byte = UTF8_LEAD;
		next_last = 1'b0;
		case (pos_q)
			POS_LEAD: next_byte = UTF8_LEAD;
			POS_MID: next_byte = UTF8_MID + {6'd0, cur_q.bits[7:6]};
			POS_TAIL: begin
				next_byte = UTF8_TAIL + {2'd0, cur_q.bits[5:0]};
				next_last = !cur_q.newline;
			end
			POS_NEWLINE: begin
				next_byte = NEWLINE;
				next_last = 1'b1;
			end
			default: next_byte = UTF8_LEAD;
		endcase
	end

	assign load = active_q && (!out_valid_q || out_ready);
	assign pop = !active_q || (load && next_last);

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q <= POS_LEAD;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= head.valid;
				pos_q <= POS_LEAD;
			end else if (load) begin
				pos_q <= byte_pos_t'(pos_q + 2'd1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.req;
		end
		if (load) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

endmodule

`default_nettype wire

// ===== src/raster_to_braille_text.sv =====
`default_nettype none

// Braille dot-art renderer. Pixels come in raster order as red, green and
// blue with a dither value; a pixel sets a dot when noise < luma, luma being
// (54r + 184g + 18b + 128) >> 8. Rows are taken in bands of four: rows 0..2
// go to a line store (MAX_WIDTH entries of 3 bits), and on row 3 every pair
// of columns completes a 2x4 cell, sent as the three UTF-8 bytes E2,
// A0+(bits>>6), 80+(bits&3F); a 0A newline follows the last cell of the row.
// tlast marks the final byte caused by a pixel. frame_start on a pixel makes
// it row 0, column 0. image_width (clamped to 2..MAX_WIDTH, made even) must
// include any padding pixels; the user is to write it only while the block is
// idle, which the block itself does not enforce. Rate: a pixel is taken every
// cycle unless a finished cell waits on a full queue; on row 3 of a band each
// cell of two pixels makes three or four bytes and the output port's one byte
// per cycle while m_axis_tready is high sets the pace there, with a two-entry
// cell queue absorbing the bursts. The line store is not cleared after reset:
// a column has to see a row 0 pixel before any other row reads it.
module raster_to_braille_text #(
	parameter int unsigned MAX_WIDTH = brtxt_pkg::BRT_MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration
	input wire logic cfg_we,
	input wire logic [brtxt_pkg::IMG_WIDTH_W-1:0] cfg_wdata,   // image_width
	// pixel requests
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata,   // red, green, blue, noise
	input wire logic s_axis_tuser,          // frame_start
	// text byte requests
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata,        // text_byte
	output logic m_axis_tlast               // last
);
	import brtxt_pkg::*;

	logic [IMG_WIDTH_W-1:0] image_width_q;
	cell_push_t push;
	cell_head_t head;
	logic queue_full;
	logic pop;

	// width register, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMG_WIDTH_RST;
		end else if (cfg_we) begin
			image_width_q <= cfg_wdata;
		end
	end

	// front: dots, line store, cell assembly
	brtxt_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(image_width_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.red(s_axis_tdata[7:0]),
		.green(s_axis_tdata[15:8]),
		.blue(s_axis_tdata[23:16]),
		.noise(s_axis_tdata[31:24]),
		.frame_start(s_axis_tuser),
		.push(push),
		.queue_full(queue_full)
	);

	// finished cells wait here so either side can stall on its own
	brtxt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(queue_full),
		.head(head),
		.pop(pop)
	);

	// back: cell to utf-8 bytes, one per cycle into the output register while it is not stalled
	brtxt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== src/brtxt_check.sv =====
`default_nettype none

module brtxt_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic m_axis_tlast
);
	import brtxt_pkg::*;

	logic xfer;
	logic expect_lead_q;

	assign xfer = m_axis_tvalid && m_axis_tready;

	// next byte opens a new character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_lead_q <= 1'b1;
		end else if (xfer) begin
			expect_lead_q <= m_axis_tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output request changed while stalled");

	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && expect_lead_q |-> m_axis_tdata == UTF8_LEAD)
		else $error("character does not open with the lead byte");

	a_newline_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && m_axis_tdata == NEWLINE |-> m_axis_tlast)
		else $error("newline not marked last");

	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && expect_lead_q |-> !m_axis_tlast)
		else $error("lead byte marked last");

endmodule

bind raster_to_braille_text brtxt_check u_check (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);

`default_nettype wire
